// File: src/hsvrgb_pkg.sv
package hsvrgb_pkg;

  // Fixed-point format of saturation, value and the color outputs.
  localparam int FRAC_BITS = 12;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

  // Hue is in degrees times 64; one sector spans 60 degrees.
  localparam int HUE_W = 15;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;
  localparam int REM_W = 12;

  // f = floor(rem * ONE / 3840) = floor((rem << (FRAC_BITS - 8)) / 15).
  // The divide by 15 is a multiply by ceil(2^23 / 15) and a shift, exact for
  // every dividend below 2^23 / 7, which covers the whole FRAC_BITS range.
  localparam int REM_SH      = FRAC_BITS - 8;
  localparam int X_W         = REM_W + REM_SH;
  localparam int RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_15 = 20'd559241;
  localparam int RECIP_SHIFT = 23;

  // Sector codes, one per 60 degrees of hue.
  localparam int SECT_W = 3;
  localparam logic [SECT_W-1:0] SECT_RED_YEL = 3'd0;
  localparam logic [SECT_W-1:0] SECT_YEL_GRN = 3'd1;
  localparam logic [SECT_W-1:0] SECT_GRN_CYN = 3'd2;
  localparam logic [SECT_W-1:0] SECT_CYN_BLU = 3'd3;
  localparam logic [SECT_W-1:0] SECT_BLU_MAG = 3'd4;
  localparam logic [SECT_W-1:0] SECT_MAG_RED = 3'd5;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [VAL_W-1:0] saturation;
    logic [VAL_W-1:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } rgb_out_t;

  // After hue split and clamping.
  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [REM_W-1:0]  rem;
    logic [VAL_W-1:0]  sat;
    logic [VAL_W-1:0]  val;
  } prep_t;

  // After the hue fraction and p are formed.
  typedef struct packed {
    logic [SECT_W-1:0]    sector;
    logic [FRAC_BITS-1:0] frac;
    logic [VAL_W-1:0]     p;
    logic [VAL_W-1:0]     sat;
    logic [VAL_W-1:0]     val;
  } frac_t;

  // After the saturation-scaled factors (1 - s*f) and (1 - s*(1-f)).
  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [VAL_W-1:0]  p;
    logic [VAL_W-1:0]  fac_q;
    logic [VAL_W-1:0]  fac_t;
    logic [VAL_W-1:0]  val;
  } factor_t;

  // All three products ready for the output ordering.
  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [VAL_W-1:0]  p;
    logic [VAL_W-1:0]  q;
    logic [VAL_W-1:0]  t;
    logic [VAL_W-1:0]  val;
  } prod_t;

endpackage

// File: src/hsvrgb_prep.sv
module hsvrgb_prep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  hsvrgb_pkg::hsv_in_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output hsvrgb_pkg::prep_t   dn_data
);
  import hsvrgb_pkg::*;

  logic [HUE_W-1:0]  hue_w;
  logic [HUE_W-1:0]  base;
  logic [SECT_W-1:0] sector;
  prep_t             data_nxt;
  prep_t             data_r;
  logic              valid_r;

  always_comb begin
    hue_w = (up_data.hue >= HUE_FULL) ? up_data.hue - HUE_FULL : up_data.hue;
    sector = SECT_RED_YEL;
    base   = '0;
    for (int k = 1; k < 6; k++) begin
      if (hue_w >= HUE_W'(k * HUE_SECTOR)) begin
        sector = SECT_W'(k);
        base   = HUE_W'(k * HUE_SECTOR);
      end
    end
    data_nxt.sector = sector;
    data_nxt.rem    = REM_W'(hue_w - base);
    data_nxt.sat    = (up_data.saturation > ONE) ? ONE : up_data.saturation;
    data_nxt.val    = (up_data.brightness > ONE) ? ONE : up_data.brightness;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  a_sector_range : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (data_r.sector <= SECT_MAG_RED) && (REM_W'(data_r.rem) < REM_W'(HUE_SECTOR)))
    else $error("hue split out of range");

endmodule

// File: src/hsvrgb_arith.sv
module hsvrgb_arith (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  hsvrgb_pkg::prep_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsvrgb_pkg::prod_t dn_data
);
  import hsvrgb_pkg::*;

  logic [X_W-1:0]             rem_x;
  logic [X_W+RECIP_W-1:0]     frac_prod;
  logic [2*VAL_W-1:0]         p_prod;
  logic [VAL_W+FRAC_BITS-1:0] sf_prod;
  logic [2*VAL_W-1:0]         sg_prod;
  logic [2*VAL_W-1:0]         q_prod;
  logic [2*VAL_W-1:0]         t_prod;

  frac_t   s2_nxt, s2_r;
  factor_t s3_nxt, s3_r;
  prod_t   s4_nxt, s4_r;
  logic    v2_r, v3_r, v4_r;
  logic    rdy2, rdy3, rdy4;

  assign rdy4     = !v4_r || dn_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign up_ready = rdy2;

  // Hue fraction and p = v*(1-s).
  always_comb begin
    rem_x     = X_W'(up_data.rem) << REM_SH;
    frac_prod = (X_W+RECIP_W)'(rem_x) * (X_W+RECIP_W)'(RECIP_15);
    p_prod    = (2*VAL_W)'(up_data.val) * (2*VAL_W)'(ONE - up_data.sat);
    s2_nxt.sector = up_data.sector;
    s2_nxt.frac   = FRAC_BITS'(frac_prod >> RECIP_SHIFT);
    s2_nxt.p      = VAL_W'(p_prod >> FRAC_BITS);
    s2_nxt.sat    = up_data.sat;
    s2_nxt.val    = up_data.val;
  end

  // Factors 1 - s*f and 1 - s*(1-f).
  always_comb begin
    sf_prod = (VAL_W+FRAC_BITS)'(s2_r.sat) * (VAL_W+FRAC_BITS)'(s2_r.frac);
    sg_prod = (2*VAL_W)'(s2_r.sat) * (2*VAL_W)'(ONE - VAL_W'(s2_r.frac));
    s3_nxt.sector = s2_r.sector;
    s3_nxt.p      = s2_r.p;
    s3_nxt.fac_q  = ONE - VAL_W'(sf_prod >> FRAC_BITS);
    s3_nxt.fac_t  = ONE - VAL_W'(sg_prod >> FRAC_BITS);
    s3_nxt.val    = s2_r.val;
  end

  // q = v * (1 - s*f), t = v * (1 - s*(1-f)).
  always_comb begin
    q_prod = (2*VAL_W)'(s3_r.val) * (2*VAL_W)'(s3_r.fac_q);
    t_prod = (2*VAL_W)'(s3_r.val) * (2*VAL_W)'(s3_r.fac_t);
    s4_nxt.sector = s3_r.sector;
    s4_nxt.p      = s3_r.p;
    s4_nxt.q      = VAL_W'(q_prod >> FRAC_BITS);
    s4_nxt.t      = VAL_W'(t_prod >> FRAC_BITS);
    s4_nxt.val    = s3_r.val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= up_valid;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && up_valid) s2_r <= s2_nxt;
    if (rdy3 && v2_r)     s3_r <= s3_nxt;
    if (rdy4 && v3_r)     s4_r <= s4_nxt;
  end

  assign dn_valid = v4_r;
  assign dn_data  = s4_r;

  a_grey_p : assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && (s2_r.sat == '0)) |-> (s2_r.p == s2_r.val))
    else $error("zero saturation must give p equal to value");

  a_factor_range : assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (s3_r.fac_q <= ONE) && (s3_r.fac_t <= ONE))
    else $error("scaled factor exceeds one");

endmodule

// File: src/hsvrgb_order.sv
module hsvrgb_order (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  hsvrgb_pkg::prod_t    up_data,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output hsvrgb_pkg::rgb_out_t dn_data
);
  import hsvrgb_pkg::*;

  rgb_out_t rgb_nxt;
  rgb_out_t rgb_r;
  logic     valid_r;

  always_comb begin
    unique case (up_data.sector)
      SECT_RED_YEL: rgb_nxt = '{red: up_data.val, green: up_data.t,   blue: up_data.p};
      SECT_YEL_GRN: rgb_nxt = '{red: up_data.q,   green: up_data.val, blue: up_data.p};
      SECT_GRN_CYN: rgb_nxt = '{red: up_data.p,   green: up_data.val, blue: up_data.t};
      SECT_CYN_BLU: rgb_nxt = '{red: up_data.p,   green: up_data.q,   blue: up_data.val};
      SECT_BLU_MAG: rgb_nxt = '{red: up_data.t,   green: up_data.p,   blue: up_data.val};
      default:      rgb_nxt = '{red: up_data.val, green: up_data.p,   blue: up_data.q};
    endcase
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = rgb_r;

  a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (rgb_r.red <= ONE) && (rgb_r.green <= ONE) && (rgb_r.blue <= ONE))
    else $error("color channel exceeds one");

endmodule

// File: src/hsv_to_rgb_converter.sv
// Channel   Direction  Payload                              Transfer when
// in_       input      hue, saturation, brightness          in_valid && in_ready
// out_      output     red, green, blue                     out_valid && out_ready
//
// The item passes five registers from an input transfer to the matching
// result being offered: hue split (loaded at the input transfer), fraction
// and p, scaled factors, q and t products, and the output register. One
// pixel can be taken every cycle while out_ready is high; the rate is set
// by the five-stage register pipeline, with at most one multiplier pair per stage.
// Reset (rst_n low, synchronous) clears every stage valid bit; data registers
// are not reset. When out_ready is low, stages fill from the output backward
// and in_ready drops only once the pipe is full, so nothing is lost or repeated.
module hsv_to_rgb_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsvrgb_pkg::hsv_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsvrgb_pkg::rgb_out_t out_data
);
  import hsvrgb_pkg::*;

  // Hue split and clamp stage to arithmetic stages.
  logic  prep_valid;
  logic  prep_ready;
  prep_t prep_data;

  // Arithmetic stages to the output ordering stage.
  logic  prod_valid;
  logic  prod_ready;
  prod_t prod_data;

  // Wrap the hue, split it into a 60-degree sector and remainder, and clamp
  // saturation and value to one.
  hsvrgb_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (prep_valid),
    .dn_ready (prep_ready),
    .dn_data  (prep_data)
  );

  // Three stages of truncating products. A zero saturation makes p, q and t
  // all equal the value, so grey needs no separate path.
  hsvrgb_arith u_arith (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prep_valid),
    .up_ready (prep_ready),
    .up_data  (prep_data),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  // Pick the channel order from the sector and hold the result for transfer.
  hsvrgb_order u_order (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_data  (prod_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

  // Every stage frees up when the consumer is ready, so the input must be too.
  a_ready_chain : assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the HSV to RGB pixel converter.
//
// Pixels go in on the in_ channel and colors come out on the out_ channel.
// Every accepted pixel is run through a fixed-point color model held here.
// The predicted color is queued and then compared with the next result
// transfer. The block keeps no state between pixels, so the queue is the
// only thing that links a result to the pixel that caused it.
module testbench;
  import hsvrgb_pkg::*;

  // Number formats of the conversion. These are kept apart from the package
  // so that the predicted products do not rest on the design's own constants.
  localparam int unsigned FRAC          = 12;
  localparam int unsigned UNITY         = 1 << FRAC;
  localparam int unsigned HUE_PER_SIXTH = 3840;   // 60 degrees times 64
  localparam int unsigned HUE_CIRCLE    = 23040;  // 360 degrees times 64
  localparam int unsigned HUE_MAX       = 32767;
  localparam int unsigned LEVEL_MAX     = 8191;
  localparam int unsigned PIPE_DEPTH    = 5;
  localparam int unsigned MAX_REPORTS   = 10;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  hsv_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b1;
  rgb_out_t out_data;

  // Predicted colors, oldest first, one for each pixel transfer whose result
  // has not come out yet.
  rgb_out_t color_queue[$];
  int unsigned mismatch_count = 0;

  // Random idling switches. Gaps on the input side and stalls on the output
  // side are turned off for the directed pixels and for the closing burst.
  bit pixel_gaps_on   = 1'b0;
  bit result_stall_on = 1'b0;
  int unsigned stall_left = 0;

  hsv_to_rgb_converter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Color model of one pixel. Hue folds back into one turn, saturation and
  // value clamp to one, and the three truncated products are placed in the
  // order given by the 60-degree sector that the hue falls in.
  function automatic rgb_out_t hsv_color(hsv_in_t pixel);
    int unsigned hue;
    int unsigned sat;
    int unsigned val;
    int unsigned sector;
    int unsigned frac;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    rgb_out_t    color;
    hue = pixel.hue;
    if (hue >= HUE_CIRCLE) begin
      hue = hue - HUE_CIRCLE;
    end
    sat = (pixel.saturation > UNITY) ? UNITY : pixel.saturation;
    val = (pixel.brightness > UNITY) ? UNITY : pixel.brightness;
    if (sat == 0) begin
      // With no saturation every channel carries the value: a grey.
      color.red   = VAL_W'(val);
      color.green = VAL_W'(val);
      color.blue  = VAL_W'(val);
      return color;
    end
    sector = hue / HUE_PER_SIXTH;
    frac   = ((hue % HUE_PER_SIXTH) << FRAC) / HUE_PER_SIXTH;
    p = (val * (UNITY - sat)) >> FRAC;
    q = (val * (UNITY - ((sat * frac) >> FRAC))) >> FRAC;
    t = (val * (UNITY - ((sat * (UNITY - frac)) >> FRAC))) >> FRAC;
    case (sector)
      SECT_RED_YEL: color = '{VAL_W'(val), VAL_W'(t), VAL_W'(p)};
      SECT_YEL_GRN: color = '{VAL_W'(q), VAL_W'(val), VAL_W'(p)};
      SECT_GRN_CYN: color = '{VAL_W'(p), VAL_W'(val), VAL_W'(t)};
      SECT_CYN_BLU: color = '{VAL_W'(p), VAL_W'(q), VAL_W'(val)};
      SECT_BLU_MAG: color = '{VAL_W'(t), VAL_W'(p), VAL_W'(val)};
      // The last sector, magenta back to red.
      default:      color = '{VAL_W'(val), VAL_W'(p), VAL_W'(q)};
    endcase
    return color;
  endfunction

  // Most pixels stay in the nominal ranges. About a quarter of the fields
  // use the whole port width, so hues past one turn and levels above one
  // come up often and every input bit sees both values.
  function automatic hsv_in_t random_pixel();
    hsv_in_t pixel;
    pixel.hue = ($urandom_range(0, 3) == 0) ? HUE_W'($urandom_range(0, HUE_MAX))
                                            : HUE_W'($urandom_range(0, HUE_CIRCLE));
    pixel.saturation = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, LEVEL_MAX))
                                                   : VAL_W'($urandom_range(0, UNITY));
    pixel.brightness = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom_range(0, LEVEL_MAX))
                                                   : VAL_W'($urandom_range(0, UNITY));
    // Greys take their own path in the color model, so give them a fair share.
    if ($urandom_range(0, 9) == 0) begin
      pixel.saturation = '0;
    end
    return pixel;
  endfunction

  // Offers one pixel from a falling edge and holds it until the transfer.
  // When gaps are on, in_valid sometimes drops low first; otherwise valid
  // stays high and only the payload changes.
  task automatic send_pixel(hsv_in_t pixel);
    int unsigned gap;
    gap = 0;
    if (pixel_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
    end
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pixel;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic send_hsv(int unsigned hue, int unsigned sat, int unsigned val);
    hsv_in_t pixel;
    pixel.hue        = HUE_W'(hue);
    pixel.saturation = VAL_W'(sat);
    pixel.brightness = VAL_W'(val);
    send_pixel(pixel);
  endtask

  // Hue corners, mostly at full saturation and value: both ends of the field,
  // every sector boundary but the last, the middle of the last sector, a full
  // turn that must read as zero, and later hues that must fold back by one turn.
  task automatic test_hue_corners();
    send_hsv(0, UNITY, UNITY);
    send_hsv(1, UNITY, UNITY);
    send_hsv(HUE_PER_SIXTH - 1, UNITY, UNITY);
    send_hsv(HUE_PER_SIXTH, UNITY, UNITY);
    send_hsv(2 * HUE_PER_SIXTH, UNITY, UNITY);
    send_hsv(3 * HUE_PER_SIXTH, UNITY, UNITY);
    send_hsv(4 * HUE_PER_SIXTH, UNITY, UNITY);
    send_hsv(5 * HUE_PER_SIXTH + 1920, UNITY, UNITY);
    send_hsv(HUE_CIRCLE - 1, UNITY, UNITY);
    send_hsv(HUE_CIRCLE, UNITY, UNITY);
    send_hsv(HUE_CIRCLE + 1, 3000, 2500);
    send_hsv(HUE_MAX, UNITY, UNITY);
  endtask

  // Saturation and value corners: greys, black, full scale, and levels above
  // one that must clamp to one, including the all-ones field.
  task automatic test_level_corners();
    send_hsv(9000, 0, 2047);
    send_hsv(HUE_MAX, 0, LEVEL_MAX);
    send_hsv(14000, UNITY, 0);
    send_hsv(17000, 1, UNITY);
    send_hsv(6000, UNITY - 1, UNITY - 1);
    send_hsv(21000, LEVEL_MAX, 3333);
    send_hsv(2000, 5000, LEVEL_MAX);
    send_hsv(12345, 2048, 6000);
  endtask

  // Random pixels with gaps on the input and stalls on the output, so that
  // the pipeline fills and drains at every depth.
  task automatic test_random_with_idling(int unsigned count);
    pixel_gaps_on   = 1'b1;
    result_stall_on = 1'b1;
    repeat (count) send_pixel(random_pixel());
    pixel_gaps_on   = 1'b0;
    result_stall_on = 1'b0;
  endtask

  // Random pixels back to back at the full rate of one per cycle while in_ready is high.
  task automatic test_full_rate(int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Lets the last results come out, then goes on watching with the input idle so
  // that a result nobody asked for would still be caught.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (color_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (PIPE_DEPTH * 4) @(negedge clk);
  endtask

  // Output side: out_ready drops in random bursts while stalls
  // are on and is high the rest of the time.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (result_stall_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Both channels are watched in one place. A pixel transfer queues its
  // color before a result transfer in the same cycle takes one off, so the
  // order never depends on how the simulator schedules the processes.
  always @(posedge clk) begin
    rgb_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        color_queue.push_back(hsv_color(in_data));
      end
      if (out_valid && out_ready) begin
        if (color_queue.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("unexpected result r=%0d g=%0d b=%0d",
                     out_data.red, out_data.green, out_data.blue);
          end
          mismatch_count++;
        end else begin
          want = color_queue.pop_front();
          if (out_data.red !== want.red || out_data.green !== want.green ||
              out_data.blue !== want.blue) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue,
                       out_data.red, out_data.green, out_data.blue);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_hue_corners();
    test_level_corners();
    test_random_with_idling(450);
    test_full_rate(200);
    drain_results();
    if (color_queue.size() != 0) begin
      $display("%0d results never arrived", color_queue.size());
      mismatch_count += color_queue.size();
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // A run that hangs on a handshake ends here. The fixed time is many times
  // the slowest correct run, with every pixel waiting out the longest gap
  // and every result the longest stall.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
